@@ hw/rtl/pwmc_pkg.sv @@
package pwmc_pkg;

  // item op codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register map
  localparam logic [7:0] ADDR_MODE     = 8'h00;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;
  localparam logic [7:0] ADDR_CH_BASE  = 8'h06;
  localparam logic [7:0] ADDR_ALL_BASE = 8'hFA;
  localparam logic [7:0] ADDR_ALL_LAST = 8'hFD;

  localparam int SLEEP_POS = 4;
  localparam logic [7:0] MODE_RESET     = 8'h10;
  localparam logic [7:0] PRESCALE_RESET = 8'd30;

  localparam int COUNT_W = 12;
  localparam int CHAN_W  = 4;
  localparam int OUT_W   = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [OUT_W-1:0] pwm_out;
  } result_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_WR_MODE,
    CMD_WR_PRESCALE,
    CMD_WR_ALL,
    CMD_WR_CH,
    CMD_RD_MODE,
    CMD_RD_PRESCALE,
    CMD_RD_CH,
    CMD_TICK
  } cmd_kind_t;

  // part: 0 on low, 1 on high, 2 off low, 3 off high
  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAN_W-1:0] chan;
    logic [1:0]        part;
    logic [7:0]        data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [COUNT_W-1:0] put_count_byte(input logic [COUNT_W-1:0] count,
                                                        input logic hi,
                                                        input logic [7:0] data);
    logic [COUNT_W-1:0] res;
    res = count;
    if (hi) begin
      res[COUNT_W-1:8] = data[3:0];
    end else begin
      res[7:0] = data;
    end
    return res;
  endfunction

  function automatic logic [7:0] get_count_byte(input logic [COUNT_W-1:0] count,
                                                input logic hi);
    logic [7:0] res;
    if (hi) begin
      res = {4'd0, count[COUNT_W-1:8]};
    end else begin
      res = count[7:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/pwmc_front.sv @@
module pwmc_front #(
  parameter int CHANNELS = 16
) (
  input  pwmc_pkg::item_t       req,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  pwmc_pkg::queue_stat_t q_stat,
  output logic                  push,
  output pwmc_pkg::cmd_t        cmd
);

  localparam logic [8:0] CH_END = 9'(32'(pwmc_pkg::ADDR_CH_BASE) + 4 * CHANNELS);

  logic [7:0] ch_off;
  logic       in_ch;
  logic       in_all;

  assign ch_off = req.reg_addr - pwmc_pkg::ADDR_CH_BASE;
  assign in_ch  = (req.reg_addr >= pwmc_pkg::ADDR_CH_BASE) && ({1'b0, req.reg_addr} < CH_END);
  assign in_all = (req.reg_addr >= pwmc_pkg::ADDR_ALL_BASE) &&
                  (req.reg_addr <= pwmc_pkg::ADDR_ALL_LAST);

  assign req_stall = q_stat.full;
  assign push      = req_valid && !q_stat.full;

  always_comb begin
    cmd.kind = pwmc_pkg::CMD_NOP;
    cmd.chan = ch_off[pwmc_pkg::CHAN_W+1:2];
    cmd.part = ch_off[1:0];
    cmd.data = req.write_data;
    if (in_all) begin
      cmd.part = 2'(req.reg_addr - pwmc_pkg::ADDR_ALL_BASE);
    end
    unique case (req.op)
      pwmc_pkg::OP_WRITE: begin
        if (req.reg_addr == pwmc_pkg::ADDR_MODE) begin
          cmd.kind = pwmc_pkg::CMD_WR_MODE;
        end else if (req.reg_addr == pwmc_pkg::ADDR_PRESCALE) begin
          cmd.kind = pwmc_pkg::CMD_WR_PRESCALE;
        end else if (in_all) begin
          cmd.kind = pwmc_pkg::CMD_WR_ALL;
        end else if (in_ch) begin
          cmd.kind = pwmc_pkg::CMD_WR_CH;
        end
      end
      pwmc_pkg::OP_READ: begin
        // all-channel addresses read back as zero
        if (req.reg_addr == pwmc_pkg::ADDR_MODE) begin
          cmd.kind = pwmc_pkg::CMD_RD_MODE;
        end else if (req.reg_addr == pwmc_pkg::ADDR_PRESCALE) begin
          cmd.kind = pwmc_pkg::CMD_RD_PRESCALE;
        end else if (in_ch) begin
          cmd.kind = pwmc_pkg::CMD_RD_CH;
        end
      end
      pwmc_pkg::OP_TICK: cmd.kind = pwmc_pkg::CMD_TICK;
      default: cmd.kind = pwmc_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ hw/rtl/pwmc_queue.sv @@
module pwmc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pwmc_pkg::cmd_t        din,
  input  logic                  pop,
  output pwmc_pkg::cmd_t        dout,
  output pwmc_pkg::queue_stat_t q_stat
);

  pwmc_pkg::cmd_t                   mem [pwmc_pkg::QUEUE_DEPTH];
  logic [pwmc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [pwmc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [pwmc_pkg::QUEUE_CNT_W-1:0] count;

  assign q_stat.full  = (count == pwmc_pkg::QUEUE_CNT_W'(pwmc_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign dout         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pwmc_back.sv @@
module pwmc_back #(
  parameter int CHANNELS    = 16,
  parameter int PHASE_STEPS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pwmc_pkg::cmd_t        cmd,
  input  pwmc_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output pwmc_pkg::result_t     rsp
);

  localparam int CW   = pwmc_pkg::COUNT_W;
  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]          mode_reg,      mode_reg_next;
  logic [7:0]          prescale_reg,  prescale_reg_next;
  logic [7:0]          divider_count, divider_count_next;
  logic [CW-1:0]       phase_count,   phase_count_next;
  logic [CHANNELS-1:0] output_levels, output_levels_next;
  logic [CW-1:0]       on_counts      [CHANNELS];
  logic [CW-1:0]       on_counts_next [CHANNELS];
  logic [CW-1:0]       off_counts      [CHANNELS];
  logic [CW-1:0]       off_counts_next [CHANNELS];

  logic [IDXW-1:0] idx;
  logic [CW:0]     phase_inc;
  logic [CW-1:0]   phase_wrap;
  logic [7:0]      rd;
  logic            asleep;

  assign idx        = cmd.chan[IDXW-1:0];
  assign asleep     = mode_reg[pwmc_pkg::SLEEP_POS];
  assign phase_inc  = {1'b0, phase_count} + 1'b1;
  assign phase_wrap = (phase_inc >= (CW+1)'(PHASE_STEPS)) ? '0 : phase_inc[CW-1:0];

  // output slot frees up when empty or being taken
  assign pop = !q_stat.empty && (!rsp_valid || !rsp_stall);

  always_comb begin
    mode_reg_next      = mode_reg;
    prescale_reg_next  = prescale_reg;
    divider_count_next = divider_count;
    phase_count_next   = phase_count;
    output_levels_next = output_levels;
    on_counts_next     = on_counts;
    off_counts_next    = off_counts;
    rd                 = '0;
    if (pop) begin
      unique case (cmd.kind)
        pwmc_pkg::CMD_WR_MODE: mode_reg_next = cmd.data;
        pwmc_pkg::CMD_WR_PRESCALE: begin
          if (asleep) begin
            prescale_reg_next = cmd.data;
          end
        end
        pwmc_pkg::CMD_WR_ALL: begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (cmd.part[1]) begin
              off_counts_next[n] = pwmc_pkg::put_count_byte(off_counts[n], cmd.part[0],
                                                            cmd.data);
            end else begin
              on_counts_next[n] = pwmc_pkg::put_count_byte(on_counts[n], cmd.part[0],
                                                           cmd.data);
            end
          end
        end
        pwmc_pkg::CMD_WR_CH: begin
          if (cmd.part[1]) begin
            off_counts_next[idx] = pwmc_pkg::put_count_byte(off_counts[idx], cmd.part[0],
                                                            cmd.data);
          end else begin
            on_counts_next[idx] = pwmc_pkg::put_count_byte(on_counts[idx], cmd.part[0],
                                                           cmd.data);
          end
        end
        pwmc_pkg::CMD_RD_MODE:     rd = mode_reg;
        pwmc_pkg::CMD_RD_PRESCALE: rd = prescale_reg;
        pwmc_pkg::CMD_RD_CH: begin
          if (cmd.part[1]) begin
            rd = pwmc_pkg::get_count_byte(off_counts[idx], cmd.part[0]);
          end else begin
            rd = pwmc_pkg::get_count_byte(on_counts[idx], cmd.part[0]);
          end
        end
        pwmc_pkg::CMD_TICK: begin
          if (!asleep) begin
            if (divider_count != prescale_reg) begin
              divider_count_next = divider_count + 1'b1;
            end else begin
              divider_count_next = '0;
              phase_count_next   = phase_wrap;
              // off wins when both counts match
              for (int n = 0; n < CHANNELS; n++) begin
                if (phase_wrap == off_counts[n]) begin
                  output_levels_next[n] = 1'b0;
                end else if (phase_wrap == on_counts[n]) begin
                  output_levels_next[n] = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= pwmc_pkg::MODE_RESET;
      prescale_reg  <= pwmc_pkg::PRESCALE_RESET;
      divider_count <= '0;
      phase_count   <= '0;
      output_levels <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        on_counts[n]  <= '0;
        off_counts[n] <= '0;
      end
      rsp_valid <= 1'b0;
    end else begin
      mode_reg      <= mode_reg_next;
      prescale_reg  <= prescale_reg_next;
      divider_count <= divider_count_next;
      phase_count   <= phase_count_next;
      output_levels <= output_levels_next;
      on_counts     <= on_counts_next;
      off_counts    <= off_counts_next;
      if (pop) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.read_data <= rd;
      rsp.pwm_out   <= pwmc_pkg::OUT_W'(output_levels_next);
    end
  end

endmodule

@@ hw/rtl/pwm_controller_16ch_registers_top.sv @@
// register-mapped pwm generator, up to 16 channels with 12-bit on/off counts
// req channel: one item per transfer (req_valid/req_stall): a byte register
//   write, a byte register read, or one oscillator tick
// rsp channel: exactly one result per item, in order (rsp_valid/rsp_stall):
//   read_data (zero unless a mapped register is read) and pwm_out, the
//   channel levels after that item
// a decode stage classifies each item into a two-entry command queue; the
//   execute stage updates the register file, divider and phase counter and
//   loads the output register
// with an idle queue an item is written to a queue entry and then registered into the
//   output register, where rsp_valid rises
// throughput: one item per cycle sustained unless rsp stalls, set by the single execute stage
// when rsp is stalled the output register holds, the queue fills, and req_stall
//   rises after two more transfers; it drops as soon as a result is taken
// reset: mode 0x10 (asleep), prescale 30, all counts, divider, phase and
//   outputs zero; no clearing pass, the block takes items right after reset
module pwm_controller_16ch_registers_top #(
  parameter int CHANNELS    = 16,
  parameter int PHASE_STEPS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pwmc_pkg::item_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pwmc_pkg::result_t rsp
);

  pwmc_pkg::queue_stat_t q_stat;
  pwmc_pkg::cmd_t        cmd_in;
  pwmc_pkg::cmd_t        cmd_out;
  logic                  push;
  logic                  pop;

  pwmc_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .req      (req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (cmd_in)
  );

  pwmc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .pop   (pop),
    .dout  (cmd_out),
    .q_stat(q_stat)
  );

  pwmc_back #(
    .CHANNELS   (CHANNELS),
    .PHASE_STEPS(PHASE_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .q_stat   (q_stat),
    .pop      (pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

`ifndef SYNTHESIS
  a_rsp_idle_after_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_req_open_after_rst: assert property (@(posedge clk) rst |=> !req_stall)
    else $error("request stalled right after reset");

  a_unused_channels_low: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((32'(rsp.pwm_out) >> CHANNELS) == 32'd0))
    else $error("level on a channel beyond the channel count");

  a_drain_frees_queue: assert property (@(posedge clk) disable iff (rst)
    (req_stall && !rsp_stall) |=> !req_stall)
    else $error("queue stayed full after a result was taken");
`endif

endmodule

@@ tb/pwm_controller_16ch_registers_top_tb.sv @@
module pwm_controller_16ch_registers_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH         = 16;
  localparam int PHASE_STEPS    = 4096;
  localparam int IDLE_PCT       = 27;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_REPORTS    = 10;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  pwmc_pkg::item_t   req       = '0;
  logic              rsp_stall = 1'b0;
  logic              req_stall;
  logic              rsp_valid;
  pwmc_pkg::result_t rsp;

  pwm_controller_16ch_registers_top #(
    .CHANNELS   (NUM_CH),
    .PHASE_STEPS(PHASE_STEPS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted register file, divider and phase
  logic [7:0]                   mode_q     = pwmc_pkg::MODE_RESET;
  logic [7:0]                   prescale_q = pwmc_pkg::PRESCALE_RESET;
  logic [pwmc_pkg::COUNT_W-1:0] on_q [NUM_CH] = '{default: '0};
  logic [pwmc_pkg::COUNT_W-1:0] off_q [NUM_CH] = '{default: '0};
  logic [7:0]                   div_q      = '0;
  logic [pwmc_pkg::COUNT_W-1:0] phase_q    = '0;
  logic [pwmc_pkg::OUT_W-1:0]   levels_q   = '0;

  pwmc_pkg::result_t pending_results [$];

  bit idle_en = 1'b1;
  int hold_req_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_reads = 0;
  int n_ticks = 0;
  int n_phase_steps = 0;
  int quiet_cycles = 0;

  function automatic void store_count_byte(input int ch, input int part,
                                           input logic [7:0] d);
    case (part)
      0: on_q[ch][7:0] = d;
      1: on_q[ch][pwmc_pkg::COUNT_W-1:8] = d[3:0];
      2: off_q[ch][7:0] = d;
      default: off_q[ch][pwmc_pkg::COUNT_W-1:8] = d[3:0];
    endcase
  endfunction

  function automatic pwmc_pkg::result_t pwm_step(input pwmc_pkg::item_t it);
    pwmc_pkg::result_t r;
    int a;
    int ch;
    int part;
    r = '0;
    a = it.reg_addr;
    case (it.op)
      pwmc_pkg::OP_WRITE: begin
        if (it.reg_addr == pwmc_pkg::ADDR_MODE) begin
          mode_q = it.write_data;
        end else if (it.reg_addr == pwmc_pkg::ADDR_PRESCALE) begin
          // prescale only sticks while asleep
          if (mode_q[pwmc_pkg::SLEEP_POS]) prescale_q = it.write_data;
        end else if (a >= pwmc_pkg::ADDR_ALL_BASE && a <= pwmc_pkg::ADDR_ALL_LAST) begin
          for (int n = 0; n < NUM_CH; n++)
            store_count_byte(n, a - pwmc_pkg::ADDR_ALL_BASE, it.write_data);
        end else if (a >= pwmc_pkg::ADDR_CH_BASE &&
                     a < pwmc_pkg::ADDR_CH_BASE + 4 * NUM_CH) begin
          store_count_byte((a - pwmc_pkg::ADDR_CH_BASE) / 4, (a - pwmc_pkg::ADDR_CH_BASE) % 4,
                           it.write_data);
        end
      end
      pwmc_pkg::OP_READ: begin
        n_reads++;
        if (it.reg_addr == pwmc_pkg::ADDR_MODE) begin
          r.read_data = mode_q;
        end else if (it.reg_addr == pwmc_pkg::ADDR_PRESCALE) begin
          r.read_data = prescale_q;
        end else if (a >= pwmc_pkg::ADDR_CH_BASE &&
                     a < pwmc_pkg::ADDR_CH_BASE + 4 * NUM_CH) begin
          ch = (a - pwmc_pkg::ADDR_CH_BASE) / 4;
          part = (a - pwmc_pkg::ADDR_CH_BASE) % 4;
          case (part)
            0: r.read_data = on_q[ch][7:0];
            1: r.read_data = {4'h0, on_q[ch][pwmc_pkg::COUNT_W-1:8]};
            2: r.read_data = off_q[ch][7:0];
            default: r.read_data = {4'h0, off_q[ch][pwmc_pkg::COUNT_W-1:8]};
          endcase
        end
      end
      pwmc_pkg::OP_TICK: begin
        n_ticks++;
        if (!mode_q[pwmc_pkg::SLEEP_POS]) begin
          if (div_q != prescale_q) begin
            div_q = div_q + 8'd1;
          end else begin
            div_q = '0;
            phase_q = (int'(phase_q) + 1 >= PHASE_STEPS) ? '0 : phase_q + 1'b1;
            n_phase_steps++;
            // off wins over on
            for (int n = 0; n < NUM_CH; n++) begin
              if (phase_q == off_q[n]) levels_q[n] = 1'b0;
              else if (phase_q == on_q[n]) levels_q[n] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.pwm_out = levels_q;
    return r;
  endfunction

  function automatic pwmc_pkg::item_t make_item(input logic [1:0] op,
                                                input logic [7:0] addr,
                                                input logic [7:0] data);
    pwmc_pkg::item_t it;
    it.op = op;
    it.reg_addr = addr;
    it.write_data = data;
    return it;
  endfunction

  // mostly ticks and count writes aimed just ahead of the phase, so edges keep firing
  function automatic pwmc_pkg::item_t next_traffic_item();
    pwmc_pkg::item_t it;
    int sel;
    int ch;
    int part;
    logic [pwmc_pkg::COUNT_W-1:0] target;
    sel = $urandom_range(0, 99);
    it = make_item(pwmc_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    if (sel < 55) begin
      it.op = pwmc_pkg::OP_TICK;
    end else if (sel < 75) begin
      ch = $urandom_range(0, NUM_CH - 1);
      part = $urandom_range(0, 3);
      target = phase_q + pwmc_pkg::COUNT_W'($urandom_range(0, 24));
      it.op = pwmc_pkg::OP_WRITE;
      it.write_data = (part % 2 == 0) ? target[7:0] :
                      {4'($urandom), target[pwmc_pkg::COUNT_W-1:8]};
      if ($urandom_range(0, 7) == 0) it.reg_addr = 8'(int'(pwmc_pkg::ADDR_ALL_BASE) + part);
      else it.reg_addr = 8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * ch + part);
    end else if (sel < 79) begin
      it.op = pwmc_pkg::OP_WRITE;
      it.reg_addr = pwmc_pkg::ADDR_MODE;
      if ($urandom_range(0, 9) < 7) it.write_data[pwmc_pkg::SLEEP_POS] = 1'b0;
    end else if (sel < 82) begin
      it.op = pwmc_pkg::OP_WRITE;
      it.reg_addr = pwmc_pkg::ADDR_PRESCALE;
      if ($urandom_range(0, 4) != 0) it.write_data = 8'($urandom_range(0, 3));
    end else if (sel < 84) begin
      it.op = pwmc_pkg::OP_WRITE;
    end else if (sel < 97) begin
      it.op = pwmc_pkg::OP_READ;
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: it.reg_addr = pwmc_pkg::ADDR_MODE;
          1: it.reg_addr = pwmc_pkg::ADDR_PRESCALE;
          default: it.reg_addr = 8'($urandom_range(int'(pwmc_pkg::ADDR_CH_BASE),
                                   int'(pwmc_pkg::ADDR_CH_BASE) + 4 * NUM_CH - 1));
        endcase
      end
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  task automatic send_item(input pwmc_pkg::item_t it);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(pwm_step(it));
    n_sent++;
  endtask

  task automatic reg_write(input logic [7:0] addr, input logic [7:0] data);
    send_item(make_item(pwmc_pkg::OP_WRITE, addr, data));
  endtask

  task automatic reg_read(input logic [7:0] addr);
    send_item(make_item(pwmc_pkg::OP_READ, addr, 8'h00));
  endtask

  task automatic send_tick();
    send_item(make_item(pwmc_pkg::OP_TICK, 8'h00, 8'h00));
  endtask

  task automatic set_channel(input int ch, input logic [pwmc_pkg::COUNT_W-1:0] on_cnt,
                             input logic [pwmc_pkg::COUNT_W-1:0] off_cnt);
    reg_write(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * ch), on_cnt[7:0]);
    reg_write(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * ch + 1),
              {4'h0, on_cnt[pwmc_pkg::COUNT_W-1:8]});
    reg_write(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * ch + 2), off_cnt[7:0]);
    reg_write(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * ch + 3),
              {4'h0, off_cnt[pwmc_pkg::COUNT_W-1:8]});
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_register_map();
    reg_read(pwmc_pkg::ADDR_MODE);
    reg_read(pwmc_pkg::ADDR_PRESCALE);
    reg_read(pwmc_pkg::ADDR_CH_BASE);
    reg_write(pwmc_pkg::ADDR_PRESCALE, 8'hFF);
    reg_read(pwmc_pkg::ADDR_PRESCALE);
    reg_write(pwmc_pkg::ADDR_PRESCALE, 8'h00);
    reg_write(pwmc_pkg::ADDR_MODE, 8'h00);
    // awake now, so this prescale write must be dropped
    reg_write(pwmc_pkg::ADDR_PRESCALE, 8'h55);
    reg_read(pwmc_pkg::ADDR_PRESCALE);
    reg_write(pwmc_pkg::ADDR_CH_BASE + 8'd1, 8'hFF);
    reg_read(pwmc_pkg::ADDR_CH_BASE + 8'd1);
    reg_write(pwmc_pkg::ADDR_ALL_BASE + 8'd2, 8'hA1);
    reg_read(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * (NUM_CH - 1) + 2));
    reg_read(pwmc_pkg::ADDR_ALL_BASE + 8'd2);
    reg_write(8'h03, 8'hFF);
    reg_read(8'h03);
    reg_write(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * NUM_CH), 8'h5A);
    reg_read(8'(int'(pwmc_pkg::ADDR_CH_BASE) + 4 * NUM_CH));
    reg_write(8'hFF, 8'h77);
    reg_read(8'hFF);
    reg_read(pwmc_pkg::ADDR_ALL_BASE - 8'd1);
    send_item(make_item(OP_NONE, 8'h00, 8'hFF));
    reg_write(pwmc_pkg::ADDR_MODE, 8'hFF);
    reg_read(pwmc_pkg::ADDR_MODE);
    send_tick();
    settle();
  endtask

  task automatic test_divider_and_edges();
    for (int p = 0; p < 4; p++) reg_write(8'(int'(pwmc_pkg::ADDR_ALL_BASE) + p), 8'h00);
    reg_write(pwmc_pkg::ADDR_MODE, pwmc_pkg::MODE_RESET);
    reg_write(pwmc_pkg::ADDR_PRESCALE, 8'hFF);
    set_channel(4, 12'd1, 12'd2);
    reg_write(pwmc_pkg::ADDR_MODE, 8'h00);
    // widest divider: 256 ticks per phase step, ends with the divider back at zero
    repeat (256) send_tick();
    reg_write(pwmc_pkg::ADDR_MODE, pwmc_pkg::MODE_RESET);
    reg_write(pwmc_pkg::ADDR_PRESCALE, 8'h00);
    set_channel(0, 12'd4, 12'd6);
    set_channel(1, 12'hFFF, 12'd2);
    set_channel(2, 12'd5, 12'd5);
    set_channel(3, 12'd8, 12'hFFE);
    reg_write(pwmc_pkg::ADDR_MODE, 8'h00);
    repeat (40) send_tick();
    settle();
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_item(next_traffic_item());
    settle();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (80) send_item(next_traffic_item());
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_stall_pressure();
    idle_en = 1'b0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (40) send_item(next_traffic_item());
    settle();
    idle_en = 1'b1;
  endtask

  // result side: random stalls plus a counted hold on request
  initial begin : result_side
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    pwmc_pkg::result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result transfer with nothing pending, pwm_out", 0, rsp.pwm_out);
      end else begin
        want = pending_results.pop_front();
        if (rsp.read_data !== want.read_data)
          flag_mismatch("read_data", want.read_data, rsp.read_data);
        if (rsp.pwm_out !== want.pwm_out)
          flag_mismatch("pwm_out", want.pwm_out, rsp.pwm_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_divider_and_edges();
    test_random_traffic(85);
    test_random_traffic(60);
    test_back_to_back();
    test_stall_pressure();
    test_random_traffic(35);
    $display("%0d transfers in, %0d results checked: %0d reads, %0d ticks, %0d phase steps",
             n_sent, n_checked, n_reads, n_ticks, n_phase_steps);
    $display("covered the register map, sleep gating, widest divider, edge priority, %0d-cycle hold",
             HOLD_CYCLES);
    if (n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
